// ===== hw/rtl/polyline_strip_offset_macros.svh =====
// Assertion macros for the polyline strip offset block.
// Used by the top level only; bodies compile away under SYNTHESIS.
`ifndef POLYLINE_STRIP_OFFSET_MACROS_SVH
`define POLYLINE_STRIP_OFFSET_MACROS_SVH

`ifndef SYNTHESIS

// Clocked implication check, off while reset is high.
`define PSO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PSO_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define PSO_ASSERT(lbl, prop, msg)
`define PSO_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/pso_pkg.sv =====
// Shared widths, constants and types for the polyline strip offset block.
// No dependencies; imported by the interfaces, the offset unit and the top level.
`timescale 1ns / 1ps

package pso_pkg;

   localparam int POS_W   = 32;   // signed position
   localparam int WIDTH_W = 31;   // unsigned rope width
   localparam int TEX_W   = 16;   // texture coordinate
   localparam int TEXS_W  = 4 * TEX_W;
   localparam int DIFF_W  = POS_W + 1;
   localparam int UNIT_W  = 31;   // unit vector component, Q1.30 magnitude
   localparam int ROOT_W  = 32;
   localparam int PROD_W  = UNIT_W + WIDTH_W;
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int SREM_W  = ROOT_W + 1;

   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = UNIT_W;
   localparam int CNT_W      = $clog2(SQRT_STEPS);

   localparam logic [UNIT_W-1:0] UNIT_ONE   = UNIT_W'(1) << (UNIT_W - 1);
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (UNIT_W - 1);

   typedef struct packed {
      logic [DIFF_W-1:0]  dx;
      logic [DIFF_W-1:0]  dy;
      logic [WIDTH_W-1:0] width;
   } pso_job_type;

   typedef struct packed {
      logic [POS_W-1:0] off_x;
      logic [POS_W-1:0] off_y;
   } pso_result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pso_status_type;

endpackage

// ===== hw/rtl/pso_req_if.sv =====
// Point channel: valid/ready handshake carrying one rope point.
// Depends on pso_pkg for field widths.
`timescale 1ns / 1ps

interface pso_req_if import pso_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   pos_x;
   logic [POS_W-1:0]   pos_y;
   logic [WIDTH_W-1:0] width;
   logic [TEX_W-1:0]   tex0_u;
   logic [TEX_W-1:0]   tex0_v;
   logic [TEX_W-1:0]   tex1_u;
   logic [TEX_W-1:0]   tex1_v;
   logic               last_point;

   modport source (
      output valid, pos_x, pos_y, width, tex0_u, tex0_v, tex1_u, tex1_v, last_point,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, width, tex0_u, tex0_v, tex1_u, tex1_v, last_point,
      output ready
   );

endinterface

// ===== hw/rtl/pso_rsp_if.sv =====
// Vertex channel: valid/ready handshake carrying one strip vertex record.
// Depends on pso_pkg for field widths.
`timescale 1ns / 1ps

interface pso_rsp_if import pso_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] center_x;
   logic [POS_W-1:0] center_y;
   logic [POS_W-1:0] offset_x;
   logic [POS_W-1:0] offset_y;
   logic [TEX_W-1:0] out_tex0_u;
   logic [TEX_W-1:0] out_tex0_v;
   logic [TEX_W-1:0] out_tex1_u;
   logic [TEX_W-1:0] out_tex1_v;
   logic             last_vertex;

   modport source (
      output valid, center_x, center_y, offset_x, offset_y,
             out_tex0_u, out_tex0_v, out_tex1_u, out_tex1_v, last_vertex,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, offset_x, offset_y,
             out_tex0_u, out_tex0_v, out_tex1_u, out_tex1_v, last_vertex,
      output ready
   );

endinterface

// ===== hw/rtl/pso_offset.sv =====
// Iterative perpendicular offset unit: normalize, square, root, divide, scale.
// One shared 31x31 multiplier; bit-serial square root and dual-lane divide.
// Depends on pso_pkg.
`timescale 1ns / 1ps

module pso_offset import pso_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  pso_job_type    job,
   output pso_status_type status,
   output pso_result_type result
);

   typedef enum logic [3:0] {
      E_IDLE, E_NORM, E_SQ_X, E_SQ_Y, E_SQ_SUM, E_SQRT, E_DIV, E_MUL_X, E_MUL_Y, E_MUL_FIN
   } eng_state_type;

   eng_state_type      state_ff;
   logic               done_ff;
   logic [DIFF_W-1:0]  ax_ff, ay_ff;
   logic               dy_pos_ff, dx_neg_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [PROD_W-1:0]  prod_ff, acc_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [SREM_W-1:0]  srem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [ROOT_W-1:0]  xrem_ff, yrem_ff;
   logic [UNIT_W-1:0]  ux_ff, uy_ff;
   logic [POS_W-1:0]   offx_ff, offy_ff;

   logic [DIFF_W-1:0]  job_ax, job_ay, m;
   logic [UNIT_W-1:0]  mul_a;
   logic [WIDTH_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_p;
   logic [UNIT_W-1:0]  ux_cap, uy_cap;
   logic [PROD_W-1:0]  rnd;
   logic [POS_W-1:0]   mag;
   logic [SREM_W+1:0]  sr2, st, sdiff;
   logic               sge;
   logic               dbit;
   logic [ROOT_W:0]    xr2, yr2, xdiff, ydiff, dlen;
   logic               xge, yge;

   assign job_ax = job.dx[DIFF_W-1] ? (DIFF_W'(0) - job.dx) : job.dx;
   assign job_ay = job.dy[DIFF_W-1] ? (DIFF_W'(0) - job.dy) : job.dy;
   assign m      = (ax_ff > ay_ff) ? ax_ff : ay_ff;

   assign ux_cap = (ux_ff > UNIT_ONE) ? UNIT_ONE : ux_ff;
   assign uy_cap = (uy_ff > UNIT_ONE) ? UNIT_ONE : uy_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         E_SQ_X: begin
            mul_a = ax_ff[UNIT_W-1:0];
            mul_b = ax_ff[WIDTH_W-1:0];
         end
         E_SQ_Y: begin
            mul_a = ay_ff[UNIT_W-1:0];
            mul_b = ay_ff[WIDTH_W-1:0];
         end
         E_MUL_X: begin
            mul_a = uy_cap;
            mul_b = width_ff;
         end
         E_MUL_Y: begin
            mul_a = ux_cap;
            mul_b = width_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // half-width scale: round half up, then drop the Q1.30 and the factor of two
   assign rnd = prod_ff + ROUND_BIAS;
   assign mag = {1'b0, rnd[PROD_W-1:UNIT_W]};

   // one root bit per step
   assign sr2   = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign st    = {1'b0, root_ff, 2'b01};
   assign sge   = (sr2 >= st);
   assign sdiff = sr2 - st;

   // one quotient bit per step in each lane; only the first step takes a numerator bit
   assign dbit  = (cnt_ff == '0);
   assign dlen  = {1'b0, root_ff};
   assign xr2   = {xrem_ff, dbit & ax_ff[0]};
   assign yr2   = {yrem_ff, dbit & ay_ff[0]};
   assign xge   = (xr2 >= dlen);
   assign yge   = (yr2 >= dlen);
   assign xdiff = xr2 - dlen;
   assign ydiff = yr2 - dlen;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  ax_ff     <= job_ax;
                  ay_ff     <= job_ay;
                  dx_neg_ff <= job.dx[DIFF_W-1];
                  dy_pos_ff <= !job.dy[DIFF_W-1] && (job.dy != '0);
                  width_ff  <= job.width;
                  state_ff  <= E_NORM;
               end
            end
            E_NORM: begin
               // bring the larger magnitude into [2^30, 2^31)
               priority if (m == '0) begin
                  offx_ff  <= '0;
                  offy_ff  <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= E_IDLE;
               end else if (m[DIFF_W-1:UNIT_W] != '0) begin
                  ax_ff <= ax_ff >> 1;
                  ay_ff <= ay_ff >> 1;
               end else if (m[UNIT_W-1]) begin
                  state_ff <= E_SQ_X;
               end else if (m[UNIT_W-2:15] == '0) begin
                  ax_ff <= ax_ff << 16;
                  ay_ff <= ay_ff << 16;
               end else if (m[UNIT_W-2:23] == '0) begin
                  ax_ff <= ax_ff << 8;
                  ay_ff <= ay_ff << 8;
               end else if (m[UNIT_W-2:27] == '0) begin
                  ax_ff <= ax_ff << 4;
                  ay_ff <= ay_ff << 4;
               end else if (!m[UNIT_W-2]) begin
                  ax_ff <= ax_ff << 2;
                  ay_ff <= ay_ff << 2;
               end else begin
                  ax_ff <= ax_ff << 1;
                  ay_ff <= ay_ff << 1;
               end
            end
            E_SQ_X: begin
               prod_ff  <= mul_p;
               state_ff <= E_SQ_Y;
            end
            E_SQ_Y: begin
               acc_ff   <= prod_ff;
               prod_ff  <= mul_p;
               state_ff <= E_SQ_SUM;
            end
            E_SQ_SUM: begin
               rad_ff   <= {1'b0, {1'b0, acc_ff} + {1'b0, prod_ff}};
               srem_ff  <= '0;
               root_ff  <= '0;
               cnt_ff   <= '0;
               state_ff <= E_SQRT;
            end
            E_SQRT: begin
               srem_ff <= sge ? sdiff[SREM_W-1:0] : sr2[SREM_W-1:0];
               root_ff <= {root_ff[ROOT_W-2:0], sge};
               rad_ff  <= rad_ff << 2;
               if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
                  xrem_ff  <= {2'b00, ax_ff[UNIT_W-1:1]};
                  yrem_ff  <= {2'b00, ay_ff[UNIT_W-1:1]};
                  ux_ff    <= '0;
                  uy_ff    <= '0;
                  cnt_ff   <= '0;
                  state_ff <= E_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_DIV: begin
               xrem_ff <= xge ? xdiff[ROOT_W-1:0] : xr2[ROOT_W-1:0];
               yrem_ff <= yge ? ydiff[ROOT_W-1:0] : yr2[ROOT_W-1:0];
               ux_ff   <= {ux_ff[UNIT_W-2:0], xge};
               uy_ff   <= {uy_ff[UNIT_W-2:0], yge};
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= E_MUL_X;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            E_MUL_X: begin
               prod_ff  <= mul_p;
               state_ff <= E_MUL_Y;
            end
            E_MUL_Y: begin
               // offset x follows the sign of -dy
               offx_ff  <= dy_pos_ff ? (POS_W'(0) - mag) : mag;
               prod_ff  <= mul_p;
               state_ff <= E_MUL_FIN;
            end
            E_MUL_FIN: begin
               offy_ff  <= dx_neg_ff ? (POS_W'(0) - mag) : mag;
               done_ff  <= 1'b1;
               state_ff <= E_IDLE;
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign status.busy  = (state_ff != E_IDLE);
   assign status.done  = done_ff;
   assign result.off_x = offx_ff;
   assign result.off_y = offy_ff;

endmodule

// ===== hw/rtl/polyline_strip_offset.sv =====
// Polyline strip offset top level: point bookkeeping, sequencing and vertex register.
// Depends on pso_pkg, pso_req_if, pso_rsp_if, pso_offset and the assertion macros.
`timescale 1ns / 1ps
`include "polyline_strip_offset_macros.svh"

// Rope points arrive on req_if, strip vertices leave on rsp_if, each a valid/ready transfer.
// Vertices lag one point: the first point of a rope gives nothing, each later point gives
// the vertex of the point before it, and the point flagged last_point gives two vertices,
// the second flagged last_vertex. A rope of one point gives nothing. Each vertex passes
// through the offset unit's normalize steps, the squared length, a bit-serial square
// root, a two-lane restoring divide and the half-width scale, all on one shared 31x31
// multiplier. A zero-length direction finishes after its first normalize step. After a
// first point the block stays ready; after an inner point it takes no point until that
// vertex is loaded into the output register, after a last point until both are, and a
// stalled sink holds it up further. A finished vertex sits in the output register; the
// next one can wait in the offset unit until that register is free.

module polyline_strip_offset import pso_pkg::*; (
   input logic        clock,
   input logic        reset,
   pso_req_if.sink    req_if,
   pso_rsp_if.source  rsp_if
);

   typedef enum logic [2:0] {
      T_IDLE, T_REC1, T_RUN1, T_PUT1, T_REC2, T_RUN2, T_PUT2
   } top_state_type;

   localparam logic [1:0] PTS_NONE  = 2'd0;
   localparam logic [1:0] PTS_FIRST = 2'd1;
   localparam logic [1:0] PTS_INNER = 2'd2;

   top_state_type      state_ff;
   logic [1:0]         pts_ff;
   logic [POS_W-1:0]   held_x_ff, held_y_ff, older_x_ff, older_y_ff;
   logic [WIDTH_W-1:0] held_w_ff;
   logic [TEXS_W-1:0]  held_tex_ff;
   logic [POS_W-1:0]   cur_x_ff, cur_y_ff;
   logic [WIDTH_W-1:0] cur_w_ff;
   logic [TEXS_W-1:0]  cur_tex_ff;
   logic               cur_last_ff;

   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_cx_ff, rsp_cy_ff, rsp_ox_ff, rsp_oy_ff;
   logic [TEXS_W-1:0]  rsp_tex_ff;
   logic               rsp_last_ff;

   logic [TEXS_W-1:0]  req_tex;
   logic [POS_W-1:0]   base_x, base_y;
   logic               eng_start;
   pso_job_type        eng_job;
   pso_status_type     eng_status;
   pso_result_type     eng_result;
   logic               out_free, load_out;

   assign req_tex = {req_if.tex1_v, req_if.tex1_u, req_if.tex0_v, req_if.tex0_u};

   // the first vertex of a rope uses the forward difference, the last one the backward one, inner ones the central one
   assign base_x = (state_ff == T_REC2 || pts_ff == PTS_FIRST) ? held_x_ff : older_x_ff;
   assign base_y = (state_ff == T_REC2 || pts_ff == PTS_FIRST) ? held_y_ff : older_y_ff;

   assign eng_start     = (state_ff == T_REC1) || (state_ff == T_REC2);
   assign eng_job.dx    = {cur_x_ff[POS_W-1], cur_x_ff} - {base_x[POS_W-1], base_x};
   assign eng_job.dy    = {cur_y_ff[POS_W-1], cur_y_ff} - {base_y[POS_W-1], base_y};
   assign eng_job.width = (state_ff == T_REC2) ? cur_w_ff : held_w_ff;

   pso_offset u_offset (
      .clock  (clock),
      .reset  (reset),
      .start  (eng_start),
      .job    (eng_job),
      .status (eng_status),
      .result (eng_result)
   );

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign load_out = ((state_ff == T_PUT1) || (state_ff == T_PUT2)) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         pts_ff       <= PTS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (req_if.valid) begin
                  cur_x_ff    <= req_if.pos_x;
                  cur_y_ff    <= req_if.pos_y;
                  cur_w_ff    <= req_if.width;
                  cur_tex_ff  <= req_tex;
                  cur_last_ff <= req_if.last_point;
                  if (pts_ff == PTS_NONE) begin
                     // open a rope; a lone last point is dropped
                     if (!req_if.last_point) begin
                        held_x_ff   <= req_if.pos_x;
                        held_y_ff   <= req_if.pos_y;
                        held_w_ff   <= req_if.width;
                        held_tex_ff <= req_tex;
                        pts_ff      <= PTS_FIRST;
                     end
                  end else begin
                     state_ff <= T_REC1;
                  end
               end
            end
            T_REC1: begin
               state_ff <= T_RUN1;
            end
            T_RUN1: begin
               if (eng_status.done) begin
                  state_ff <= T_PUT1;
               end
            end
            T_PUT1: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cx_ff    <= held_x_ff;
                  rsp_cy_ff    <= held_y_ff;
                  rsp_ox_ff    <= eng_result.off_x;
                  rsp_oy_ff    <= eng_result.off_y;
                  rsp_tex_ff   <= held_tex_ff;
                  rsp_last_ff  <= 1'b0;
                  if (cur_last_ff) begin
                     state_ff <= T_REC2;
                  end else begin
                     // advance the window by one point
                     older_x_ff  <= held_x_ff;
                     older_y_ff  <= held_y_ff;
                     held_x_ff   <= cur_x_ff;
                     held_y_ff   <= cur_y_ff;
                     held_w_ff   <= cur_w_ff;
                     held_tex_ff <= cur_tex_ff;
                     pts_ff      <= PTS_INNER;
                     state_ff    <= T_IDLE;
                  end
               end
            end
            T_REC2: begin
               state_ff <= T_RUN2;
            end
            T_RUN2: begin
               if (eng_status.done) begin
                  state_ff <= T_PUT2;
               end
            end
            T_PUT2: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cx_ff    <= cur_x_ff;
                  rsp_cy_ff    <= cur_y_ff;
                  rsp_ox_ff    <= eng_result.off_x;
                  rsp_oy_ff    <= eng_result.off_y;
                  rsp_tex_ff   <= cur_tex_ff;
                  rsp_last_ff  <= 1'b1;
                  pts_ff       <= PTS_NONE;
                  state_ff     <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == T_IDLE);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.center_x    = rsp_cx_ff;
   assign rsp_if.center_y    = rsp_cy_ff;
   assign rsp_if.offset_x    = rsp_ox_ff;
   assign rsp_if.offset_y    = rsp_oy_ff;
   assign rsp_if.out_tex0_u  = rsp_tex_ff[TEX_W-1:0];
   assign rsp_if.out_tex0_v  = rsp_tex_ff[2*TEX_W-1:TEX_W];
   assign rsp_if.out_tex1_u  = rsp_tex_ff[3*TEX_W-1:2*TEX_W];
   assign rsp_if.out_tex1_v  = rsp_tex_ff[4*TEX_W-1:3*TEX_W];
   assign rsp_if.last_vertex = rsp_last_ff;

   `PSO_ASSERT(a_ready_engine_idle, req_if.ready |-> !eng_status.busy, "point taken while offset unit busy")
   `PSO_ASSERT(a_done_while_waiting, eng_status.done |-> (state_ff == T_RUN1 || state_ff == T_RUN2), "offset result with no waiting record")
   `PSO_NEVER(a_no_overwrite, load_out && rsp_valid_ff && !rsp_if.ready, "vertex register overwritten before transfer")

endmodule

// ===== tb/sv/pso_vertex_checker.sv =====
// Vertex checker for the polyline strip offset block: predicts the strip vertices of
// each accepted point and compares every accepted vertex with the oldest prediction.
// Depends on pso_pkg, pso_req_if and pso_rsp_if.
`timescale 1ns / 1ps

module pso_vertex_checker import pso_pkg::*; (
   input  logic clock,
   input  logic reset,
   pso_req_if   req_mon,
   pso_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   vertices_pending
);

   localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
   localparam logic [63:0] TOP_Q31  = 64'd1 << 31;

   typedef struct packed {
      logic [POS_W-1:0] cx;
      logic [POS_W-1:0] cy;
      logic [POS_W-1:0] ox;
      logic [POS_W-1:0] oy;
      logic [TEX_W-1:0] t0u;
      logic [TEX_W-1:0] t0v;
      logic [TEX_W-1:0] t1u;
      logic [TEX_W-1:0] t1v;
      logic             last;
   } strip_vertex_t;

   strip_vertex_t           expected_vertices[$];
   strip_vertex_t           want;
   logic signed [POS_W-1:0] held_x, held_y, older_x, older_y;
   logic [WIDTH_W-1:0]      held_w;
   logic [TEXS_W-1:0]       held_tex;
   logic [1:0]              points_held;
   int                      errors = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root, bitv;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > v)
         bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Rotate the direction by +90 degrees, normalize it and scale it by half the width.
   function automatic void half_width_normal(input longint dx, input longint dy,
                                             input logic [WIDTH_W-1:0] w,
                                             output logic [POS_W-1:0] ox,
                                             output logic [POS_W-1:0] oy);
      logic [63:0] ax, ay, top, len, ux, uy, mx, my;
      ax = (dx < 0) ? 64'(-dx) : 64'(dx);
      ay = (dy < 0) ? 64'(-dy) : 64'(dy);
      top = (ax > ay) ? ax : ay;
      if (top == 0) begin
         ox = '0;
         oy = '0;
         return;
      end
      // bring the larger magnitude into [2^30, 2^31), truncating on the way down
      while (top >= TOP_Q31) begin
         ax >>= 1;
         ay >>= 1;
         top >>= 1;
      end
      while (top < UNIT_Q30) begin
         ax <<= 1;
         ay <<= 1;
         top <<= 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      ux = (ax << 30) / len;
      uy = (ay << 30) / len;
      if (ux > UNIT_Q30)
         ux = UNIT_Q30;
      if (uy > UNIT_Q30)
         uy = UNIT_Q30;
      // half width folds into the extra shift; round half up on the magnitude
      mx = (uy * 64'(w) + UNIT_Q30) >> 31;
      my = (ux * 64'(w) + UNIT_Q30) >> 31;
      ox = (dy > 0) ? -mx[POS_W-1:0] : mx[POS_W-1:0];
      oy = (dx < 0) ? -my[POS_W-1:0] : my[POS_W-1:0];
   endfunction

   function automatic strip_vertex_t make_vertex(input logic [POS_W-1:0] cx,
                                                 input logic [POS_W-1:0] cy,
                                                 input longint dx, input longint dy,
                                                 input logic [WIDTH_W-1:0] w,
                                                 input logic [TEXS_W-1:0] tex,
                                                 input logic last);
      strip_vertex_t v;
      logic [POS_W-1:0] ox, oy;
      half_width_normal(dx, dy, w, ox, oy);
      v.cx   = cx;
      v.cy   = cy;
      v.ox   = ox;
      v.oy   = oy;
      v.t0u  = tex[15:0];
      v.t0v  = tex[31:16];
      v.t1u  = tex[47:32];
      v.t1v  = tex[63:48];
      v.last = last;
      return v;
   endfunction

   function automatic void clear_rope();
      held_x      = '0;
      held_y      = '0;
      held_w      = '0;
      held_tex    = '0;
      older_x     = '0;
      older_y     = '0;
      points_held = '0;
   endfunction

   function automatic void predict_point();
      logic signed [POS_W-1:0] px, py, bx, by;
      logic [TEXS_W-1:0]       tex;
      px  = req_mon.pos_x;
      py  = req_mon.pos_y;
      tex = {req_mon.tex1_v, req_mon.tex1_u, req_mon.tex0_v, req_mon.tex0_u};
      if (points_held == 0) begin
         if (!req_mon.last_point) begin
            held_x      = px;
            held_y      = py;
            held_w      = req_mon.width;
            held_tex    = tex;
            points_held = 2'd1;
         end
         return;
      end
      // forward difference for the first point, central difference after it
      bx = (points_held == 1) ? held_x : older_x;
      by = (points_held == 1) ? held_y : older_y;
      expected_vertices.push_back(make_vertex(held_x, held_y,
                                              longint'(px) - longint'(bx),
                                              longint'(py) - longint'(by),
                                              held_w, held_tex, 1'b0));
      if (req_mon.last_point) begin
         expected_vertices.push_back(make_vertex(px, py,
                                                 longint'(px) - longint'(held_x),
                                                 longint'(py) - longint'(held_y),
                                                 req_mon.width, tex, 1'b1));
         clear_rope();
      end else begin
         older_x     = held_x;
         older_y     = held_y;
         held_x      = px;
         held_y      = py;
         held_w      = req_mon.width;
         held_tex    = tex;
         points_held = 2'd2;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         errors++;
         $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_rope();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_point();
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_vertices.size() == 0) begin
               errors++;
               $display("%0t: vertex expected none, got center %h %h offset %h %h",
                        $time, rsp_mon.center_x, rsp_mon.center_y,
                        rsp_mon.offset_x, rsp_mon.offset_y);
            end else begin
               want = expected_vertices.pop_front();
               check_field("center_x", want.cx, rsp_mon.center_x);
               check_field("center_y", want.cy, rsp_mon.center_y);
               check_field("offset_x", want.ox, rsp_mon.offset_x);
               check_field("offset_y", want.oy, rsp_mon.offset_y);
               check_field("out_tex0_u", 32'(want.t0u), 32'(rsp_mon.out_tex0_u));
               check_field("out_tex0_v", 32'(want.t0v), 32'(rsp_mon.out_tex0_v));
               check_field("out_tex1_u", 32'(want.t1u), 32'(rsp_mon.out_tex1_u));
               check_field("out_tex1_v", 32'(want.t1v), 32'(rsp_mon.out_tex1_v));
               check_field("last_vertex", 32'(want.last), 32'(rsp_mon.last_vertex));
            end
         end
      end
      mismatch_count   <= errors;
      vertices_pending <= expected_vertices.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the polyline strip offset testbench: clock, reset, rope stimulus, sink stalls
// and the verdict. Depends on pso_pkg, both channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module testbench import pso_pkg::*; ();

   localparam int ROPE_POINTS  = 1434;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [WIDTH_W-1:0] w;
      logic [TEX_W-1:0]   t0u;
      logic [TEX_W-1:0]   t0v;
      logic [TEX_W-1:0]   t1u;
      logic [TEX_W-1:0]   t1v;
      logic               last;
   } rope_point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   src_idle_pct = 10;
   int   snk_idle_pct = 70;
   bit   hold_req = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   vertices_pending;

   pso_req_if req_ch ();
   pso_rsp_if rsp_ch ();

   polyline_strip_offset dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   pso_vertex_checker vertex_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .mismatch_count   (mismatch_count),
      .vertices_pending (vertices_pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("polyline_strip_offset: mismatch");
      $finish;
   end

   // Sink side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
         end
      end
   end

   function automatic rope_point_t make_point(input logic [POS_W-1:0] x,
                                              input logic [POS_W-1:0] y,
                                              input logic [WIDTH_W-1:0] w,
                                              input logic [TEX_W-1:0] t0u,
                                              input logic [TEX_W-1:0] t0v,
                                              input logic [TEX_W-1:0] t1u,
                                              input logic [TEX_W-1:0] t1v,
                                              input logic last);
      rope_point_t p;
      p.x    = x;
      p.y    = y;
      p.w    = w;
      p.t0u  = t0u;
      p.t0v  = t0v;
      p.t1u  = t1u;
      p.t1v  = t1v;
      p.last = last;
      return p;
   endfunction

   task automatic offer_point(input rope_point_t p);
      if ($urandom_range(99, 0) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < src_idle_pct);
      end
      req_ch.valid      <= 1'b1;
      req_ch.pos_x      <= p.x;
      req_ch.pos_y      <= p.y;
      req_ch.width      <= p.w;
      req_ch.tex0_u     <= p.t0u;
      req_ch.tex0_v     <= p.t0v;
      req_ch.tex1_u     <= p.t1u;
      req_ch.tex1_v     <= p.t1v;
      req_ch.last_point <= p.last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic random_rope(output int len);
      rope_point_t             p;
      logic signed [POS_W-1:0] step;
      int                      roll, shape;
      roll  = $urandom_range(99, 0);
      len   = (roll < 6) ? 1 : (roll < 20) ? 2 : $urandom_range(12, 3);
      shape = $urandom_range(3, 0);
      for (int i = 0; i < len; i++) begin
         if (i == 0 || shape == 0) begin
            p.x = $urandom;
            p.y = $urandom;
         end else if (!(shape == 2 && $urandom_range(3, 0) == 0)) begin
            // walk: wide steps for shape 3, narrower otherwise; repeats give zero length
            step = $urandom;
            p.x  = p.x + (step >>> $urandom_range(31, (shape == 3) ? 0 : 8));
            step = $urandom;
            p.y  = p.y + (step >>> $urandom_range(31, (shape == 3) ? 0 : 8));
         end
         case ($urandom_range(9, 0))
            0:       p.w = '0;
            1:       p.w = '1;
            2, 3, 4: p.w = WIDTH_W'($urandom_range(64 << 16, 0));
            default: p.w = WIDTH_W'($urandom);
         endcase
         p.t0u  = TEX_W'($urandom);
         p.t0v  = TEX_W'($urandom);
         p.t1u  = TEX_W'($urandom);
         p.t1v  = TEX_W'($urandom);
         p.last = (i == len - 1);
         offer_point(p);
      end
   endtask

   initial begin
      int rope_len;
      int rope_points;
      bit hold_done;
      rope_points = 0;
      hold_done   = 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.pos_x      <= '0;
      req_ch.pos_y      <= '0;
      req_ch.width      <= '0;
      req_ch.tex0_u     <= '0;
      req_ch.tex0_v     <= '0;
      req_ch.tex1_u     <= '0;
      req_ch.tex1_v     <= '0;
      req_ch.last_point <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single point rope with every field at its top: no vertex
      offer_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      // two-point rope across the whole coordinate range
      offer_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, '1,
                             16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));
      offer_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, '0,
                             16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1));
      // coincident points: zero-length direction throughout
      repeat (2)
         offer_point(make_point(32'h0001_2345, 32'hFFFE_0000, 31'h0004_0000,
                                16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b0));
      offer_point(make_point(32'h0001_2345, 32'hFFFE_0000, 31'h0004_0000,
                             16'h5555, 16'h6666, 16'h7777, 16'h8888, 1'b1));
      // axis-aligned square
      offer_point(make_point(32'h0000_0000, 32'h0000_0000, 31'h0002_0000,
                             16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b0));
      offer_point(make_point(32'h0001_0000, 32'h0000_0000, 31'h0002_0000,
                             16'h4000, 16'h0000, 16'h8000, 16'h8000, 1'b0));
      offer_point(make_point(32'h0001_0000, 32'h0001_0000, 31'h0002_0000,
                             16'h8000, 16'h0000, 16'h8000, 16'h8000, 1'b0));
      offer_point(make_point(32'h0000_0000, 32'h0001_0000, 31'h0002_0000,
                             16'hC000, 16'h0000, 16'h8000, 16'h8000, 1'b1));
      // one-LSB steps at the widest width
      offer_point(make_point(32'd5, 32'd5, '1, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0));
      offer_point(make_point(32'd6, 32'd5, '1, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 1'b0));
      offer_point(make_point(32'd6, 32'd6, '1, 16'h0009, 16'h000A, 16'h000B, 16'h000C, 1'b1));
      // inner point whose neighbors coincide: central difference is zero
      offer_point(make_point(32'h0064_0000, 32'h0000_0000, 31'h0003_0000,
                             16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0));
      offer_point(make_point(32'h0000_0000, 32'h0032_0000, 31'h0003_0000,
                             16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
      offer_point(make_point(32'h0064_0000, 32'h0000_0000, 31'h0003_0000,
                             16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));

      while (rope_points < ROPE_POINTS) begin
         if (rope_points >= 2 * ROPE_POINTS / 3) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end else if (rope_points >= ROPE_POINTS / 3) begin
            src_idle_pct = 70;
            snk_idle_pct = 10;
         end
         // long sink hold-off while points keep coming, so the block backs up
         if (!hold_done && rope_points >= ROPE_POINTS / 2) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
         random_rope(rope_len);
         if (rope_len > 1)
            rope_points += rope_len;
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (vertices_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && vertices_pending == 0)
         $display("polyline_strip_offset: match");
      else
         $display("polyline_strip_offset: mismatch");
      $finish;
   end

endmodule
